// File: design/jac_pkg.sv
// Shared types, constants and helper functions for the Jaccard distance block.
// Used by every module of the block and by the channel interfaces.
`default_nettype none

package jac_pkg;

  // Chunk geometry: one byte lane per byte of a 64-bit chunk.
  localparam int LANES      = 8;
  localparam int BYTE_W     = 8;
  localparam int CHUNK_W    = LANES * BYTE_W;
  localparam int BCNT_W     = 4;
  localparam int LANE_CNT_W = 4;
  localparam int SUM_W      = 7;

  // Counter and result widths.
  localparam int CNT_W  = 17;
  localparam int UNI_W  = CNT_W + 1;
  localparam int DIST_W = 17;

  localparam int MAX_WORDS = 1024;

  localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};
  localparam logic [DIST_W-1:0] ONE_Q16 = DIST_W'(65536);

  // Popcounts found by one byte lane.
  typedef struct packed {
    logic [LANE_CNT_W-1:0] both;
    logic [LANE_CNT_W-1:0] ones_a;
    logic [LANE_CNT_W-1:0] ones_b;
  } lane_cnt_t;

  // Totals of one vector pair, handed from the merge stage to the divider.
  typedef struct packed {
    logic [CNT_W-1:0] inter;
    logic [CNT_W-1:0] ones_a;
    logic [CNT_W-1:0] ones_b;
    logic             too_long;
  } pair_tot_t;

  // One finished result.
  typedef struct packed {
    logic [DIST_W-1:0] distance_q16;
    logic [CNT_W-1:0]  intersect_count;
    logic [CNT_W-1:0]  union_count;
    logic              too_long;
  } result_t;

  // Number of set bits in one byte.
  function automatic logic [LANE_CNT_W-1:0] popcount8(input logic [BYTE_W-1:0] x);
    logic [LANE_CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + LANE_CNT_W'(x[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/jac_if.sv
// Valid/ready channel interfaces for chunk input and result output.
// Depends on jac_pkg for the field widths.
`default_nettype none

interface jac_in_if;
  logic                          valid;
  logic                          ready;
  logic [jac_pkg::CHUNK_W-1:0]   a_chunk;
  logic [jac_pkg::CHUNK_W-1:0]   b_chunk;
  logic [jac_pkg::BCNT_W-1:0]    byte_count;
  logic                          last_chunk;

  modport source (output valid, a_chunk, b_chunk, byte_count, last_chunk, input ready);
  modport sink   (input valid, a_chunk, b_chunk, byte_count, last_chunk, output ready);
endinterface

interface jac_out_if;
  logic                        valid;
  logic                        ready;
  logic [jac_pkg::DIST_W-1:0]  distance_q16;
  logic [jac_pkg::CNT_W-1:0]   intersect_count;
  logic [jac_pkg::CNT_W-1:0]   union_count;
  logic                        too_long;

  modport source (output valid, distance_q16, intersect_count, union_count, too_long,
                  input ready);
  modport sink   (input valid, distance_q16, intersect_count, union_count, too_long,
                  output ready);
endinterface

`default_nettype wire

// File: design/jac_lane.sv
// One byte lane: registered popcounts of A AND B, A and B for its byte.
// Depends on jac_pkg.
`default_nettype none

module jac_lane (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic                        active,
  input  wire logic [jac_pkg::BYTE_W-1:0]  a_byte,
  input  wire logic [jac_pkg::BYTE_W-1:0]  b_byte,
  output jac_pkg::lane_cnt_t               cnt
);

  jac_pkg::lane_cnt_t cnt_next;

  // An inactive lane (byte outside the chunk, or chunk past the limit) adds nothing.
  always_comb begin
    if (active) begin
      cnt_next.both   = jac_pkg::popcount8(a_byte & b_byte);
      cnt_next.ones_a = jac_pkg::popcount8(a_byte);
      cnt_next.ones_b = jac_pkg::popcount8(b_byte);
    end else begin
      cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: design/jac_merge.sv
// Merge stage: sums the lane popcounts and keeps the saturating running totals.
// Depends on jac_pkg.
`default_nettype none

module jac_merge (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                valid,
  input  wire logic                last,
  input  wire logic                over,
  input  wire jac_pkg::lane_cnt_t  lanes [jac_pkg::LANES],
  output jac_pkg::pair_tot_t       tot,
  output logic                     launch
);

  logic [jac_pkg::CNT_W-1:0] both_ones;
  logic [jac_pkg::CNT_W-1:0] ones_in_a;
  logic [jac_pkg::CNT_W-1:0] ones_in_b;

  logic [jac_pkg::SUM_W-1:0] sum_both;
  logic [jac_pkg::SUM_W-1:0] sum_a;
  logic [jac_pkg::SUM_W-1:0] sum_b;

  function automatic logic [jac_pkg::CNT_W-1:0] sat_add(
    input logic [jac_pkg::CNT_W-1:0] acc,
    input logic [jac_pkg::SUM_W-1:0] inc
  );
    logic [jac_pkg::CNT_W:0] s;
    s = {1'b0, acc} + (jac_pkg::CNT_W+1)'(inc);
    return s[jac_pkg::CNT_W] ? jac_pkg::CNT_MAX : s[jac_pkg::CNT_W-1:0];
  endfunction

  // Add up what the lanes found in this chunk.
  always_comb begin
    sum_both = '0;
    sum_a    = '0;
    sum_b    = '0;
    for (int i = 0; i < jac_pkg::LANES; i++) begin
      sum_both = sum_both + jac_pkg::SUM_W'(lanes[i].both);
      sum_a    = sum_a    + jac_pkg::SUM_W'(lanes[i].ones_a);
      sum_b    = sum_b    + jac_pkg::SUM_W'(lanes[i].ones_b);
    end
  end

  // Totals including the current chunk go straight to the divider on a last chunk.
  always_comb begin
    tot.inter    = sat_add(both_ones, sum_both);
    tot.ones_a   = sat_add(ones_in_a, sum_a);
    tot.ones_b   = sat_add(ones_in_b, sum_b);
    tot.too_long = over;
  end

  assign launch = valid && last;

  // Running totals clear after the last chunk of a pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      both_ones <= '0;
      ones_in_a <= '0;
      ones_in_b <= '0;
    end else if (valid) begin
      if (last) begin
        both_ones <= '0;
        ones_in_a <= '0;
        ones_in_b <= '0;
      end else begin
        both_ones <= tot.inter;
        ones_in_a <= tot.ones_a;
        ones_in_b <= tot.ones_b;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/jac_div.sv
// Final stage: union, difference and a bit-serial restoring divide for the Q16 distance.
// Depends on jac_pkg.
`default_nettype none

module jac_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire jac_pkg::pair_tot_t  tot,
  input  wire logic                ack,
  output logic                     busy,
  output logic                     done,
  output jac_pkg::result_t         res
);

  localparam int QUO_W  = jac_pkg::DIST_W;
  localparam int DIVR_W = jac_pkg::UNI_W + 1;
  localparam int NUM_W  = jac_pkg::UNI_W + QUO_W + 1;
  localparam int STEP_W = $clog2(QUO_W + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                  state;
  jac_pkg::pair_tot_t          tot_q;
  logic [jac_pkg::UNI_W-1:0]   uni;
  logic [jac_pkg::UNI_W-1:0]   diff;
  logic [DIVR_W-1:0]           rem;
  logic [QUO_W-1:0]            low;
  logic [QUO_W-1:0]            quot;
  logic [STEP_W-1:0]           steps;

  logic [NUM_W-1:0]            num;
  logic [DIVR_W+1:0]           trial;
  logic [DIVR_W:0]             shifted;

  // Numerator is 2*(union - intersection)*65536 + union; the divisor is 2*union.
  assign num     = {1'b0, diff, {QUO_W{1'b0}}} + NUM_W'(uni);
  assign shifted = {rem, low[QUO_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, uni, 1'b0};

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  always_comb begin
    res.distance_q16    = quot;
    res.intersect_count = tot_q.inter;
    res.union_count     = uni[jac_pkg::UNI_W-1] ? jac_pkg::CNT_MAX
                                                 : uni[jac_pkg::CNT_W-1:0];
    res.too_long        = tot_q.too_long;
  end

  // Sequencer: capture, form union and difference, load, iterate, hold the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (start) state <= ST_PREP;
        ST_PREP: state <= ST_LOAD;
        ST_LOAD: state <= (tot_q.inter == '0 || uni == '0) ? ST_DONE : ST_RUN;
        ST_RUN:  if (steps == STEP_W'(1)) state <= ST_DONE;
        ST_DONE: if (ack) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) tot_q <= tot;
      end
      ST_PREP: begin
        uni  <= jac_pkg::UNI_W'(tot_q.ones_a) + jac_pkg::UNI_W'(tot_q.ones_b)
                - jac_pkg::UNI_W'(tot_q.inter);
        diff <= jac_pkg::UNI_W'(tot_q.ones_a) + jac_pkg::UNI_W'(tot_q.ones_b)
                - {tot_q.inter, 1'b0};
      end
      ST_LOAD: begin
        // An empty intersection reads as distance 1.0.
        quot  <= jac_pkg::ONE_Q16;
        rem   <= num[NUM_W-1:QUO_W];
        low   <= num[QUO_W-1:0];
        steps <= STEP_W'(QUO_W);
      end
      ST_RUN: begin
        // One quotient bit per cycle.
        if (!trial[DIVR_W+1]) begin
          rem <= trial[DIVR_W-1:0];
        end else begin
          rem <= shifted[DIVR_W-1:0];
        end
        quot  <= {quot[QUO_W-2:0], ~trial[DIVR_W+1]};
        low   <= {low[QUO_W-2:0], 1'b0};
        steps <= steps - STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/bit_vector_jaccard_distance.sv
// Jaccard distance of two bit vectors streamed in 64-bit chunks: top level.
// Depends on jac_pkg, jac_if, jac_lane, jac_merge and jac_div.
//
// Usage:
//   Chunks arrive on the chunk channel (valid/ready); a transaction is taken when
//   both are high. Eight byte lanes popcount A AND B, A and B of the bytes below
//   byte_count, and a merge stage adds them into saturating running totals.
//   Chunks that are not marked last are taken one per cycle without a break.
//   The last chunk of a pair starts the final stage: the union and difference are
//   formed and a restoring divider produces one quotient bit per cycle. Chunks of
//   the next pair are held off from the cycle after a last chunk until its result
//   has moved to the output register.
//   The output register holds a result until the receiver takes it; while it is
//   full, a finished divide waits in the divider and no further chunks are taken
//   until the divider hands its result over.
//   Chunks beyond MAX_WORDS in one pair are not counted and set too_long.
//   Synchronous reset clears all totals, counters and valid flags.
`default_nettype none

module bit_vector_jaccard_distance #(
  parameter int MAX_WORDS = jac_pkg::MAX_WORDS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  jac_in_if.sink      chunk,
  jac_out_if.source   result
);

  localparam int SEEN_W = $clog2(MAX_WORDS + 1);

  logic [SEEN_W-1:0]          chunks_seen;
  logic                       overflowed;
  logic                       s1_valid;
  logic                       s1_last;
  logic                       s1_over;
  logic                       accept;
  logic                       at_limit;
  logic [jac_pkg::BCNT_W-1:0] nbytes;
  jac_pkg::lane_cnt_t         lane_cnt [jac_pkg::LANES];
  jac_pkg::pair_tot_t         tot;
  logic                       launch;
  logic                       div_busy;
  logic                       div_done;
  jac_pkg::result_t           div_res;
  logic                       out_valid;
  jac_pkg::result_t           out_res;
  logic                       out_load;

  // Hold off new chunks while a pair's result is on its way to the output register.
  assign chunk.ready = !(div_busy || (s1_valid && s1_last));
  assign accept      = chunk.valid && chunk.ready;
  assign at_limit    = (chunks_seen == SEEN_W'(MAX_WORDS));
  assign nbytes      = (chunk.byte_count > jac_pkg::BCNT_W'(jac_pkg::LANES))
                       ? jac_pkg::BCNT_W'(jac_pkg::LANES) : chunk.byte_count;

  // Chunk count and overflow flag of the current pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_seen <= '0;
      overflowed  <= 1'b0;
    end else if (accept) begin
      if (chunk.last_chunk) begin
        chunks_seen <= '0;
        overflowed  <= 1'b0;
      end else if (at_limit) begin
        overflowed <= 1'b1;
      end else begin
        chunks_seen <= chunks_seen + SEEN_W'(1);
      end
    end
  end

  // Lane stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= chunk.last_chunk;
      s1_over <= overflowed || at_limit;
    end
  end

  // Byte lanes.
  for (genvar j = 0; j < jac_pkg::LANES; j++) begin : g_lane
    jac_lane u_lane (
      .clk    (clk),
      .load   (accept),
      .active (!at_limit && (jac_pkg::BCNT_W'(j) < nbytes)),
      .a_byte (chunk.a_chunk[j*jac_pkg::BYTE_W +: jac_pkg::BYTE_W]),
      .b_byte (chunk.b_chunk[j*jac_pkg::BYTE_W +: jac_pkg::BYTE_W]),
      .cnt    (lane_cnt[j])
    );
  end

  jac_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .valid  (s1_valid),
    .last   (s1_last),
    .over   (s1_over),
    .lanes  (lane_cnt),
    .tot    (tot),
    .launch (launch)
  );

  jac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (launch),
    .tot   (tot),
    .ack   (out_load),
    .busy  (div_busy),
    .done  (div_done),
    .res   (div_res)
  );

  // Output register: filled when empty or when its transaction completes.
  assign out_load = div_done && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= div_res;
    end
  end

  assign result.valid           = out_valid;
  assign result.distance_q16    = out_res.distance_q16;
  assign result.intersect_count = out_res.intersect_count;
  assign result.union_count     = out_res.union_count;
  assign result.too_long        = out_res.too_long;

endmodule

`default_nettype wire

// File: bench/jaccard_result_checker.sv
`timescale 1ns / 1ps
// Checker for the Jaccard distance block: watches the chunk and result channels,
// keeps its own running popcounts and compares every result in arrival order.
// Depends on jac_pkg and on the channel interfaces of jac_if.
module jaccard_result_checker #(
  parameter int MAX_WORDS = jac_pkg::MAX_WORDS
) (
  input  logic clk,
  input  logic rst,
  jac_in_if    chunk,
  jac_out_if   result,
  output int   fail_count,
  output int   pending
);

  // Running totals of the pair that is streaming in.
  logic [jac_pkg::CNT_W-1:0] tally_both;
  logic [jac_pkg::CNT_W-1:0] tally_a;
  logic [jac_pkg::CNT_W-1:0] tally_b;
  int unsigned               chunks_taken;
  logic                      pair_overflow;

  // Results of finished pairs that have not yet left the block.
  jac_pkg::result_t awaited_results[$];

  // Popcount totals stop at the top of the counter range.
  function automatic logic [jac_pkg::CNT_W-1:0] add_clamped(
    input logic [jac_pkg::CNT_W-1:0] acc,
    input int unsigned inc
  );
    longint unsigned total;
    total = longint'(acc) + inc;
    return (total > jac_pkg::CNT_MAX) ? jac_pkg::CNT_MAX : jac_pkg::CNT_W'(total);
  endfunction

  // Distance, intersection and union of the totals gathered so far.
  function automatic jac_pkg::result_t jaccard_of_totals();
    longint unsigned  inter;
    longint unsigned  uni;
    longint unsigned  dist_q16;
    jac_pkg::result_t r;
    inter = tally_both;
    uni   = longint'(tally_a) + tally_b - inter;
    // An empty intersection, which includes two empty vectors, is a full distance.
    if (inter == 0 || uni == 0) begin
      dist_q16 = jac_pkg::ONE_Q16;
    end else begin
      dist_q16 = (2 * (uni - inter) * jac_pkg::ONE_Q16 + uni) / (2 * uni);
    end
    r.distance_q16    = jac_pkg::DIST_W'(dist_q16);
    r.intersect_count = jac_pkg::CNT_W'(inter);
    r.union_count     = (uni > jac_pkg::CNT_MAX) ? jac_pkg::CNT_MAX : jac_pkg::CNT_W'(uni);
    r.too_long        = pair_overflow;
    return r;
  endfunction

  task automatic clear_tallies();
    tally_both    = '0;
    tally_a       = '0;
    tally_b       = '0;
    chunks_taken  = 0;
    pair_overflow = 1'b0;
  endtask

  // Fold one accepted chunk into the totals; a last chunk closes the pair.
  task automatic accumulate_chunk();
    logic [jac_pkg::CHUNK_W-1:0] keep;
    logic [jac_pkg::CHUNK_W-1:0] a;
    logic [jac_pkg::CHUNK_W-1:0] b;
    int unsigned                 nbytes;
    // Counts above eight act as a full chunk; zero keeps no byte at all.
    nbytes = (chunk.byte_count > jac_pkg::LANES) ? jac_pkg::LANES : chunk.byte_count;
    keep   = (nbytes == jac_pkg::LANES) ? '1
             : ((jac_pkg::CHUNK_W'(1) << (jac_pkg::BYTE_W * nbytes)) - 1);
    // Chunks past the limit are dropped but still mark the pair as too long.
    if (chunks_taken >= MAX_WORDS) begin
      pair_overflow = 1'b1;
    end else begin
      a          = chunk.a_chunk & keep;
      b          = chunk.b_chunk & keep;
      tally_both = add_clamped(tally_both, $countones(a & b));
      tally_a    = add_clamped(tally_a, $countones(a));
      tally_b    = add_clamped(tally_b, $countones(b));
      chunks_taken++;
    end
    if (chunk.last_chunk) begin
      awaited_results.push_back(jaccard_of_totals());
      clear_tallies();
    end
  endtask

  // Compare one accepted result with the oldest expectation, field by field.
  task automatic compare_result();
    jac_pkg::result_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: distance_q16 %0d, intersect_count %0d, union_count %0d",
             result.distance_q16, result.intersect_count, result.union_count);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      if (result.distance_q16 !== want.distance_q16) begin
        $error("distance_q16 mismatch: expected %0d, actual %0d",
               want.distance_q16, result.distance_q16);
        fail_count++;
      end
      if (result.intersect_count !== want.intersect_count) begin
        $error("intersect_count mismatch: expected %0d, actual %0d",
               want.intersect_count, result.intersect_count);
        fail_count++;
      end
      if (result.union_count !== want.union_count) begin
        $error("union_count mismatch: expected %0d, actual %0d",
               want.union_count, result.union_count);
        fail_count++;
      end
      if (result.too_long !== want.too_long) begin
        $error("too_long mismatch: expected %0d, actual %0d",
               want.too_long, result.too_long);
        fail_count++;
      end
    end
  endtask

  // Results are handled before chunks; a chunk never yields a result at once.
  always @(posedge clk) begin
    if (rst) begin
      clear_tallies();
      awaited_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        compare_result();
      end
      if (chunk.valid && chunk.ready) begin
        accumulate_chunk();
      end
    end
    pending = awaited_results.size();
  end

endmodule

// File: bench/tb_bit_vector_jaccard_distance.sv
`timescale 1ns / 1ps
// Testbench top for bit_vector_jaccard_distance: drives vector pairs as chunks,
// throttles both channels and gives the verdict. Depends on jac_pkg, jac_if,
// the block itself and jaccard_result_checker.
module tb_bit_vector_jaccard_distance;

  localparam int LONG_STALL_CYCLES = 300;
  localparam int WATCHDOG_LIMIT    = 3000;
  localparam int DRAIN_CYCLES      = 40;
  localparam int PHASE_ITEMS       = 178;

  // Kinds of content for one random vector pair.
  typedef enum int {
    FILL_RANDOM,
    FILL_EQUAL,
    FILL_DISJOINT,
    FILL_SPARSE,
    FILL_ONE_FLIP,
    FILL_DENSE,
    FILL_EMPTY,
    FILL_SUPERSET
  } fill_t;

  logic clk = 1'b0;
  logic rst;
  int   tx_idle_pct    = 0;
  int   rx_stall_pct   = 0;
  bit   long_stall_req = 1'b0;
  int   items_sent     = 0;
  int   quiet_cycles   = 0;
  int   fail_count;
  int   pending;

  jac_in_if  chunk_ch ();
  jac_out_if result_ch ();

  bit_vector_jaccard_distance #(
    .MAX_WORDS(jac_pkg::MAX_WORDS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .chunk  (chunk_ch),
    .result (result_ch)
  );

  jaccard_result_checker #(
    .MAX_WORDS(jac_pkg::MAX_WORDS)
  ) distance_checker (
    .clk        (clk),
    .rst        (rst),
    .chunk      (chunk_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The run ends when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (chunk_ch.valid && chunk_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end
      result_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [jac_pkg::CHUNK_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one chunk after any random idle cycles and wait for its transaction.
  task automatic send_chunk(input logic [jac_pkg::CHUNK_W-1:0] a,
                            input logic [jac_pkg::CHUNK_W-1:0] b,
                            input logic [jac_pkg::BCNT_W-1:0] nbytes, input logic last);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      chunk_ch.valid <= 1'b0;
      @(posedge clk);
    end
    chunk_ch.valid      <= 1'b1;
    chunk_ch.a_chunk    <= a;
    chunk_ch.b_chunk    <= b;
    chunk_ch.byte_count <= nbytes;
    chunk_ch.last_chunk <= last;
    do @(posedge clk); while (!chunk_ch.ready);
    items_sent++;
  endtask

  // One vector pair of the given length with content of a random kind.
  task automatic send_pair(input int len);
    fill_t                       fill;
    logic [jac_pkg::CHUNK_W-1:0] a;
    logic [jac_pkg::CHUNK_W-1:0] b;
    logic [jac_pkg::BCNT_W-1:0]  nbytes;
    logic                        last;
    fill = fill_t'($urandom_range(7));
    for (int k = 0; k < len; k++) begin
      a = rand64();
      b = rand64();
      case (fill)
        FILL_EQUAL:    b = a;
        FILL_DISJOINT: b = ~a;
        FILL_SPARSE: begin
          a = a & rand64() & rand64();
          b = b & rand64() & rand64();
        end
        FILL_ONE_FLIP: b = a ^ (jac_pkg::CHUNK_W'(1) << $urandom_range(jac_pkg::CHUNK_W - 1));
        FILL_DENSE: begin
          a = a | rand64() | rand64();
          b = b | rand64() | rand64();
        end
        FILL_EMPTY: begin
          a = '0;
          b = $urandom_range(1) ? '0 : b;
        end
        FILL_SUPERSET: b = a | b;
        default: ;
      endcase
      last = (k == len - 1);
      // Full chunks inside the pair, a short tail, and now and then any count.
      if ($urandom_range(15) == 0) begin
        nbytes = jac_pkg::BCNT_W'($urandom_range(15));
      end else if (last) begin
        nbytes = jac_pkg::BCNT_W'($urandom_range(jac_pkg::LANES, 1));
      end else begin
        nbytes = jac_pkg::BCNT_W'(jac_pkg::LANES);
      end
      send_chunk(a, b, nbytes, last);
    end
  endtask

  // Random pairs, mostly short, until the phase has sent its share of chunks.
  task automatic run_phase(input int tx_idle, input int rx_stall, input int budget);
    int sent_at_start;
    tx_idle_pct   = tx_idle;
    rx_stall_pct  = rx_stall;
    sent_at_start = items_sent;
    while (items_sent - sent_at_start < budget) begin
      send_pair(($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1));
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    chunk_ch.valid      <= 1'b0;
    chunk_ch.a_chunk    <= '0;
    chunk_ch.b_chunk    <= '0;
    chunk_ch.byte_count <= '0;
    chunk_ch.last_chunk <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs: empty and full vectors, masking and rounding.
    send_chunk('0, '0, 4'd8, 1'b1);
    send_chunk('1, '1, 4'd8, 1'b1);
    send_chunk('1, '0, 4'd8, 1'b1);
    send_chunk('0, '1, 4'd8, 1'b1);
    // A chunk with no bytes, alone and at the head of a pair.
    send_chunk('1, '1, 4'd0, 1'b1);
    send_chunk('1, '1, 4'd0, 1'b0);
    send_chunk(64'h03, 64'h06, 4'd1, 1'b1);
    // Counts above eight behave as eight.
    send_chunk('1, '1, 4'd15, 1'b1);
    send_chunk('1, 64'h0F0F_0F0F_0F0F_0F0F, 4'd9, 1'b1);
    // Top byte kept, then masked off.
    send_chunk(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 4'd8, 1'b1);
    send_chunk(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 4'd7, 1'b1);
    // A pair across several chunks with partial tails.
    send_chunk(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 4'd8, 1'b0);
    send_chunk(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 4'd4, 1'b0);
    send_chunk(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 4'd5, 1'b1);
    send_chunk(64'h00FF_00FF_00FF_00FF, 64'h0F0F_0F0F_0F0F_0F0F, 4'd2, 1'b1);
    send_chunk(64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF1, 4'd3, 1'b1);
    send_chunk(64'hFFFF_FFFF_0000_0000, 64'h0000_FFFF_FFFF_0000, 4'd6, 1'b1);

    // Hold the receiver off while the sender keeps streaming short pairs.
    long_stall_req = 1'b1;
    repeat (8) send_pair(3);

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(69, 0, PHASE_ITEMS);
    run_phase(0, 69, PHASE_ITEMS);
    run_phase(22, 22, PHASE_ITEMS);

    // Drain every outstanding result, then watch for strays.
    chunk_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
